[hdl/order_status_table_macros.svh]
// Assertion macros used by the order status table RTL.
`ifndef ORDER_STATUS_TABLE_MACROS_SVH
`define ORDER_STATUS_TABLE_MACROS_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define OST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define OST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ost_pkg.sv]
// Types, codes and tables of the order status table.
`default_nettype none

package ost_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int S_DATA_W = 152;
    localparam int M_DATA_W = 152;

    // Order status codes
    typedef enum logic [2:0] {
        STATUS_NEW        = 3'd0,
        STATUS_PENDING    = 3'd1,
        STATUS_ACCEPTED   = 3'd2,
        STATUS_PARTFILLED = 3'd3,
        STATUS_FILLED     = 3'd4,
        STATUS_CANCELED   = 3'd5,
        STATUS_REJECTED   = 3'd6,
        STATUS_EXPIRED    = 3'd7
    } status_t;

    // Request kinds
    localparam logic OP_NEW    = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // Execution report codes; the last code carries no meaning
    localparam logic [1:0] REP_ACCEPTED = 2'd0;
    localparam logic [1:0] REP_FILLED   = 2'd1;
    localparam logic [1:0] REP_REJECTED = 2'd2;
    localparam logic [1:0] REP_NONE     = 2'd3;

    // Result outcomes
    localparam logic [1:0] OUT_UPDATED = 2'd0;
    localparam logic [1:0] OUT_UNKNOWN = 2'd1;
    localparam logic [1:0] OUT_ILLEGAL = 2'd2;
    localparam logic [1:0] OUT_FULL    = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_DRAIN,
        SEQ_FINISH
    } seq_state_t;

    // One table entry as stored in memory
    typedef struct packed {
        logic [31:0] key;
        status_t     status;
        logic [31:0] filled;
    } entry_t;

    // Legal status moves
    function automatic logic legal_move(status_t from_st, status_t to_st);
        logic ok;
        ok = 1'b0;
        case (from_st)
            STATUS_NEW:
                ok = (to_st == STATUS_PENDING) || (to_st == STATUS_ACCEPTED) ||
                     (to_st == STATUS_REJECTED);
            STATUS_PENDING:
                ok = (to_st == STATUS_ACCEPTED) || (to_st == STATUS_REJECTED);
            STATUS_ACCEPTED:
                ok = (to_st == STATUS_PARTFILLED) || (to_st == STATUS_FILLED) ||
                     (to_st == STATUS_CANCELED) || (to_st == STATUS_REJECTED);
            STATUS_PARTFILLED:
                ok = (to_st == STATUS_PARTFILLED) || (to_st == STATUS_FILLED) ||
                     (to_st == STATUS_CANCELED);
            default:
                ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Report code to order status; the meaningless code maps to STATUS_NEW
    function automatic status_t report_status(logic [1:0] rep);
        status_t st;
        case (rep)
            REP_ACCEPTED: st = STATUS_ACCEPTED;
            REP_FILLED:   st = STATUS_FILLED;
            REP_REJECTED: st = STATUS_REJECTED;
            default:      st = STATUS_NEW;
        endcase
        return st;
    endfunction

endpackage

`default_nettype wire

[hdl/order_status_table.sv]
// Top level of the order status table: lookup scan, update and result register.
//
//  channel  | dir | tdata                                   | tuser
//  s_axis   | in  | order_key, initial_status, exec_status, | opcode
//           |     | fill_quantity, event_time, sequence_no. |
//  m_axis   | out | order_key_out, new_status, prior_status,| outcome
//           |     | filled_amount, time_out, sequence_out   |
//
// One request is handled at a time, from accept through the update step:
// the entry memory is scanned one entry per cycle through its single read port.
// Reset clears the valid bits at once; no clearing pass is needed.
// A finished result waits in the output register; the next request is taken
// meanwhile, and only the final update step waits for that register to free.
`default_nettype none

`include "order_status_table_macros.svh"

module order_status_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] order_key, [34:32] initial_status, [36:35] exec_status,
    // [68:37] fill_quantity, [116:69] event_time, [148:117] sequence_number
    input  wire logic [ost_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [0] opcode
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] order_key_out, [34:32] new_status, [37:35] prior_status,
    // [69:38] filled_amount, [117:70] time_out, [149:118] sequence_out
    output logic [ost_pkg::M_DATA_W-1:0] m_axis_tdata,
    // [1:0] outcome
    output logic [1:0]       m_axis_tuser
);

    localparam int IW = ost_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ost_pkg::TABLE_ENTRIES - 1);

    // Request registers
    logic        op_reg;
    logic [31:0] id_reg;
    logic [2:0]  init_reg;
    logic [1:0]  exec_reg;
    logic [31:0] qty_reg;
    logic [47:0] time_reg;
    logic [31:0] seq_reg;

    // Control registers
    ost_pkg::seq_state_t state_reg, state_next;
    logic [IW-1:0] scan_idx_reg, scan_idx_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0] cmp_idx_reg;
    logic          hit_reg, free_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;
    ost_pkg::status_t hit_status_reg;
    logic [31:0]   hit_filled_reg;
    logic [ost_pkg::TABLE_ENTRIES-1:0] valid_reg;
    logic          out_valid_reg;
    logic [ost_pkg::M_DATA_W-1:0] out_data_reg;
    logic [1:0]    out_user_reg;

    // Memory port
    ost_pkg::entry_t rd_entry, wr_entry;
    logic [IW-1:0]   wr_idx;
    logic            ram_we;

    // Final-step results
    logic             slot_ok;
    logic [1:0]       res_outcome;
    ost_pkg::status_t res_new, res_prior, rep_st;
    logic [31:0]      res_filled;
    logic             res_store, res_free, out_free, finish_go;

    logic in_accept;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ost_pkg::SEQ_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign finish_go     = (state_reg == ost_pkg::SEQ_FINISH) && out_free;

    ost_ram #(
        .WIDTH ($bits(ost_pkg::entry_t)),
        .DEPTH (ost_pkg::TABLE_ENTRIES)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx),
        .wdata (wr_entry),
        .raddr (scan_idx_reg),
        .rdata (rd_entry)
    );

    // Sequencer: scan addresses, drain the compare stage, then update
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        cmp_vld_next  = 1'b0;
        case (state_reg)
            ost_pkg::SEQ_IDLE:
            begin
                scan_idx_next = '0;
                if (in_accept)
                begin
                    state_next = ost_pkg::SEQ_SCAN;
                end
            end
            ost_pkg::SEQ_SCAN:
            begin
                cmp_vld_next = 1'b1;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ost_pkg::SEQ_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ost_pkg::SEQ_DRAIN:
            begin
                state_next = ost_pkg::SEQ_FINISH;
            end
            ost_pkg::SEQ_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ost_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = ost_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Decide the update from the scan results
    always_comb
    begin
        rep_st      = ost_pkg::report_status(exec_reg);
        res_outcome = ost_pkg::OUT_UPDATED;
        res_new     = ost_pkg::STATUS_NEW;
        res_prior   = ost_pkg::STATUS_NEW;
        res_filled  = '0;
        res_store   = 1'b0;
        res_free    = 1'b0;
        slot_ok     = hit_reg || free_reg;
        wr_idx      = hit_reg ? hit_idx_reg : free_idx_reg;
        if (op_reg == ost_pkg::OP_NEW)
        begin
            if (slot_ok)
            begin
                res_new    = ost_pkg::status_t'(init_reg);
                res_filled = qty_reg;
                res_store  = 1'b1;
            end
            else
            begin
                res_outcome = ost_pkg::OUT_FULL;
            end
        end
        else if (!hit_reg)
        begin
            res_outcome = ost_pkg::OUT_UNKNOWN;
        end
        else
        begin
            res_prior = hit_status_reg;
            if (exec_reg == ost_pkg::REP_NONE ||
                !ost_pkg::legal_move(hit_status_reg, rep_st))
            begin
                res_outcome = ost_pkg::OUT_ILLEGAL;
                res_new     = hit_status_reg;
                res_filled  = hit_filled_reg;
            end
            else
            begin
                res_new    = rep_st;
                res_filled = (rep_st == ost_pkg::STATUS_FILLED) ? qty_reg : hit_filled_reg;
                res_store  = 1'b1;
                res_free   = (rep_st >= ost_pkg::STATUS_FILLED);
            end
        end
        wr_entry.key    = id_reg;
        wr_entry.status = res_new;
        wr_entry.filled = res_filled;
        ram_we          = finish_go && res_store;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ost_pkg::SEQ_IDLE;
            scan_idx_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            cmp_vld_reg  <= cmp_vld_next;
            if (in_accept)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else if (cmp_vld_reg)
            begin
                if (valid_reg[cmp_idx_reg] && rd_entry.key == id_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (!valid_reg[cmp_idx_reg])
                begin
                    free_reg <= 1'b1;
                end
            end
            if (ram_we)
            begin
                valid_reg[wr_idx] <= !res_free;
            end
            if (finish_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture, compare stage and result payload
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_idx_reg;
        if (in_accept)
        begin
            op_reg   <= s_axis_tuser;
            id_reg   <= s_axis_tdata[31:0];
            init_reg <= s_axis_tdata[34:32];
            exec_reg <= s_axis_tdata[36:35];
            qty_reg  <= s_axis_tdata[68:37];
            time_reg <= s_axis_tdata[116:69];
            seq_reg  <= s_axis_tdata[148:117];
        end
        if (cmp_vld_reg)
        begin
            if (valid_reg[cmp_idx_reg] && rd_entry.key == id_reg && !hit_reg)
            begin
                hit_idx_reg    <= cmp_idx_reg;
                hit_status_reg <= rd_entry.status;
                hit_filled_reg <= rd_entry.filled;
            end
            if (!valid_reg[cmp_idx_reg] && !free_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
        if (finish_go)
        begin
            out_user_reg <= res_outcome;
            out_data_reg <= {2'b00, seq_reg, time_reg, res_filled,
                             res_prior, res_new, id_reg};
        end
    end

    // Checks
    `OST_ASSERT_IMP(a_write_in_finish, clk, rst_n, ram_we,
        state_reg == ost_pkg::SEQ_FINISH, "entry write outside the update step")
    `OST_ASSERT_IMP(a_compare_in_scan, clk, rst_n, cmp_vld_reg,
        state_reg == ost_pkg::SEQ_SCAN || state_reg == ost_pkg::SEQ_DRAIN,
        "compare stage active outside the scan")
    `OST_ASSERT_NEXT(a_finish_loads_out, clk, rst_n, finish_go,
        out_valid_reg && state_reg == ost_pkg::SEQ_IDLE,
        "update step did not load the result register")
    `OST_ASSERT_IMP(a_unknown_zero, clk, rst_n,
        out_valid_reg && out_user_reg == ost_pkg::OUT_UNKNOWN,
        out_data_reg[69:32] == '0, "unknown order result carries nonzero fields")

endmodule

`default_nettype wire

[hdl/ost_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ost_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
